### rtl/core/ftr_pkg.sv
// Shared types and constants for the FLV zero-timestamp rewriter.
// No dependencies; every other file in rtl/core uses it by scoped names.
package ftr_pkg;

   // FLV layout
   localparam int unsigned FileHdrLen     = 13;  // 9-byte header plus first previous-tag size
   localparam int unsigned TagHdrLast     = 10;  // last byte index of an 11-byte tag header
   localparam int unsigned PrevTagSizeLen = 4;
   localparam logic [7:0]  TagTypeAudio   = 8'd8;
   localparam logic [7:0]  TagTypeVideo   = 8'd9;

   localparam int unsigned PosW  = 4;
   localparam int unsigned SkipW = 25;

   // Result queue
   localparam int unsigned FifoDepth = 8;
   localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
   localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
   localparam int unsigned BurstMax  = 3;

   typedef enum logic [1:0] {
      PH_FILE = 2'd0,
      PH_TAG  = 2'd1,
      PH_SKIP = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_replaced;
      logic       run_last;
   } rsp_type;

   // Results caused by one request: item[0] goes out first
   typedef struct packed {
      logic [1:0]                  count;
      rsp_type [BurstMax-1:0]      item;
   } burst_type;

   typedef struct packed {
      logic [FifoCntW-1:0] level;
      logic                pop;
   } fifo_status_type;

endpackage

### rtl/core/ftr_parser.sv
// Tag parser: tracks file/tag header position and builds the results of one byte.
// Depends on ftr_pkg.
module ftr_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  ftr_pkg::req_type req_data,
   input  logic [31:0]      stamp,
   output ftr_pkg::burst_type burst
);

   ftr_pkg::phase_type          phase_ff, phase_in, phase_cur;
   logic [ftr_pkg::PosW-1:0]    pos_ff, pos_in, pos_cur;
   logic [7:0]                  type_ff, type_in, type_cur;
   logic [ftr_pkg::SkipW-1:0]   skip_ff, skip_in, skip_cur, skip_dec;
   logic [7:0]                  held0_ff, held0_in, held0_cur;
   logic [7:0]                  held1_ff, held1_in, held1_cur;
   logic [7:0]                  any_stamp;
   logic                        av_tag;
   logic [7:0]                  b;

   always_comb begin
      b         = req_data.in_byte;
      // restart clears parsing state before the byte is handled
      phase_cur = req_data.start_of_file ? ftr_pkg::PH_FILE : phase_ff;
      pos_cur   = req_data.start_of_file ? '0 : pos_ff;
      type_cur  = req_data.start_of_file ? '0 : type_ff;
      skip_cur  = req_data.start_of_file ? '0 : skip_ff;
      held0_cur = req_data.start_of_file ? '0 : held0_ff;
      held1_cur = req_data.start_of_file ? '0 : held1_ff;

      av_tag    = (type_cur == ftr_pkg::TagTypeAudio) || (type_cur == ftr_pkg::TagTypeVideo);
      any_stamp = held0_cur | held1_cur | b;
      skip_dec  = skip_cur - ftr_pkg::SkipW'(1);

      phase_in = phase_cur;
      pos_in   = pos_cur;
      type_in  = type_cur;
      skip_in  = skip_cur;
      held0_in = held0_cur;
      held1_in = held1_cur;

      burst         = '0;
      burst.count   = 2'd1;
      burst.item[0] = '{out_byte: b, byte_replaced: 1'b0, run_last: 1'b1};

      case (phase_cur)
         ftr_pkg::PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_in = ftr_pkg::PH_TAG;
               pos_in   = '0;
            end
         end
         ftr_pkg::PH_TAG: begin
            pos_in = pos_cur + ftr_pkg::PosW'(1);
            if (pos_cur == 4'd0) begin
               type_in = b;
               skip_in = '0;
            end else if (pos_cur <= 4'd3) begin
               // big-endian data size, 24 bits
               skip_in = {1'b0, skip_cur[15:0], b};
            end else if (pos_cur == 4'd4) begin
               held0_in    = b;
               burst.count = 2'd0;
            end else if (pos_cur == 4'd5) begin
               held1_in    = b;
               burst.count = 2'd0;
            end else if (pos_cur == 4'd6) begin
               burst.count = 2'd3;
               if (any_stamp == 8'd0 && av_tag) begin
                  burst.item[0] = '{out_byte: stamp[23:16], byte_replaced: 1'b1, run_last: 1'b0};
                  burst.item[1] = '{out_byte: stamp[15:8],  byte_replaced: 1'b1, run_last: 1'b0};
                  burst.item[2] = '{out_byte: stamp[7:0],   byte_replaced: 1'b1, run_last: 1'b1};
               end else begin
                  burst.item[0] = '{out_byte: held0_cur, byte_replaced: 1'b0, run_last: 1'b0};
                  burst.item[1] = '{out_byte: held1_cur, byte_replaced: 1'b0, run_last: 1'b0};
                  burst.item[2] = '{out_byte: b,         byte_replaced: 1'b0, run_last: 1'b1};
               end
               // keep the OR of the timestamp for the extended byte
               held0_in = any_stamp;
               held1_in = '0;
            end else if (pos_cur == 4'd7) begin
               if (held0_cur == 8'd0 && av_tag) begin
                  burst.item[0] = '{out_byte: stamp[31:24], byte_replaced: 1'b1, run_last: 1'b1};
               end
            end else if (pos_cur >= ftr_pkg::PosW'(ftr_pkg::TagHdrLast)) begin
               skip_in  = skip_cur + ftr_pkg::SkipW'(ftr_pkg::PrevTagSizeLen);
               phase_in = ftr_pkg::PH_SKIP;
               pos_in   = '0;
            end
         end
         default: begin
            pos_in = pos_cur + ftr_pkg::PosW'(1);
            if (pos_in >= ftr_pkg::PosW'(ftr_pkg::FileHdrLen)) begin
               phase_in = ftr_pkg::PH_TAG;
               pos_in   = '0;
            end else begin
               phase_in = ftr_pkg::PH_FILE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ftr_pkg::PH_FILE;
         pos_ff   <= '0;
         type_ff  <= '0;
         skip_ff  <= '0;
         held0_ff <= '0;
         held1_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         type_ff  <= type_in;
         skip_ff  <= skip_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

endmodule

### rtl/core/ftr_out_fifo.sv
// Result queue: takes up to three results per cycle, gives one per cycle while rsp_stall is low.
// Depends on ftr_pkg.
module ftr_out_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ftr_pkg::burst_type        burst,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output ftr_pkg::rsp_type          rsp_data,
   output ftr_pkg::fifo_status_type  status
);

   ftr_pkg::rsp_type              mem_ff [ftr_pkg::FifoDepth];
   logic [ftr_pkg::FifoPtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ftr_pkg::FifoPtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ftr_pkg::FifoCntW-1:0]  level_ff, level_in;
   logic [ftr_pkg::FifoPtrW-1:0]  wr_idx [ftr_pkg::BurstMax];
   logic [1:0]                    n_push;
   logic                          pop;

   always_comb begin
      n_push    = push ? burst.count : 2'd0;
      rsp_valid = (level_ff != '0);
      rsp_data  = mem_ff[rd_ptr_ff];
      pop       = rsp_valid && !rsp_stall;
      for (int k = 0; k < ftr_pkg::BurstMax; k++) begin
         wr_idx[k] = wr_ptr_ff + ftr_pkg::FifoPtrW'(k);
      end
      wr_ptr_in = wr_ptr_ff + ftr_pkg::FifoPtrW'(n_push);
      rd_ptr_in = rd_ptr_ff + ftr_pkg::FifoPtrW'(pop);
      level_in  = level_ff + ftr_pkg::FifoCntW'(n_push) - ftr_pkg::FifoCntW'(pop);
      status.level = level_ff;
      status.pop   = pop;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ftr_pkg::BurstMax; k++) begin
         if (ftr_pkg::FifoCntW'(k) < ftr_pkg::FifoCntW'(n_push)) begin
            mem_ff[wr_idx[k]] <= burst.item[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

### rtl/core/flv_zero_timestamp_rewriter.sv
// Top level of the FLV zero-timestamp rewriter: parser, result queue, CSR.
// Depends on ftr_pkg, ftr_parser and ftr_out_fifo.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   req     | in        | req_valid/req_stall| req_data: in_byte, start_of_file
//   rsp     | out       | rsp_valid/rsp_stall| rsp_data: out_byte, byte_replaced,
//           |           |                    |           run_last
//   csr     | in        | csr_valid/csr_ready| csr_data: replacement timestamp
//
// One request per cycle is taken while req_stall is low; the parser decides all
// results of a byte in the accept cycle and pushes them into an 8-entry result
// queue, where each result is registered before it shows on rsp.
// Tag header byte 6 pushes three results and bytes 4 and 5 push none, so the
// queue absorbs the burst and the stream keeps one byte per cycle while rsp_stall is low.
// req_stall rises only when the queue has fewer than three free entries.
// Synchronous reset clears parser state, queue pointers and the CSR; csr_ready
// is always high.
module flv_zero_timestamp_rewriter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ftr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ftr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   logic [31:0]                stamp_ff;
   logic                       req_accept;
   ftr_pkg::burst_type         burst;
   ftr_pkg::fifo_status_type   fifo_status;

   // Hold off new bytes until a full three-result burst is sure to fit
   assign req_stall  = fifo_status.level >
                       ftr_pkg::FifoCntW'(ftr_pkg::FifoDepth - ftr_pkg::BurstMax);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         stamp_ff <= csr_data;
      end
   end

   ftr_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_data (req_data),
      .stamp    (stamp_ff),
      .burst    (burst)
   );

   ftr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .burst     (burst),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (fifo_status)
   );

   // Queue never overfills
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= ftr_pkg::FifoCntW'(ftr_pkg::FifoDepth))
      else $error("result queue level above depth");

   // Queue level tracks pushes and pops
   a_level_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fifo_status.level ==
         $past(fifo_status.level) + ftr_pkg::FifoCntW'($past(req_accept ? burst.count : 2'd0))
         - ftr_pkg::FifoCntW'($past(fifo_status.pop)))
      else $error("result queue level lost track");

   // A three-result burst ends its run only on the last result
   a_burst_last: assert property (@(posedge clock) disable iff (reset)
      (req_accept && burst.count == 2'd3) |->
         (!burst.item[0].run_last && !burst.item[1].run_last && burst.item[2].run_last))
      else $error("run_last misplaced in burst");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule
